// ===== rtl/drs_pkg.sv =====
package drs_pkg;

    // Set capacity and stored value width.
    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 16;

    // Width of the value fields at the ports.
    localparam int IO_BITS = 16;

    localparam int RADIX   = 10;
    localparam int DIGIT_W = $clog2(RADIX);
    localparam int IDX_W   = $clog2(MAX_ITEMS);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);

    // Divide by ten as a multiply by a truncated reciprocal followed by one correction step.
    localparam int          DIV10_SHIFT   = VALUE_BITS + 3;
    localparam logic [63:0] DIV10_RECIP_L = (64'd1 << DIV10_SHIFT) / 64'd10;
    localparam logic [VALUE_BITS-1:0] DIV10_RECIP = DIV10_RECIP_L[VALUE_BITS-1:0];

    localparam int COPY_BITS = (VALUE_BITS < IO_BITS) ? VALUE_BITS : IO_BITS;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [DIGIT_W-1:0]    t_digit;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // One stored element: the value itself and its quotient by the current digit weight.
    typedef struct packed {
        t_value value;
        t_value quot;
    } t_elem;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_MAXDIV,
        ST_MAXSET,
        ST_EMIT
    } t_state;

    function automatic t_value to_val(input logic [IO_BITS-1:0] v);
        t_value r;
        r = '0;
        for (int b = 0; b < COPY_BITS; b++) begin
            r[b] = v[b];
        end
        return r;
    endfunction

    function automatic logic [IO_BITS-1:0] from_val(input t_value v);
        logic [IO_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < COPY_BITS; b++) begin
            r[b] = v[b];
        end
        return r;
    endfunction

endpackage

// ===== rtl/decimal_radix_sorter_unit.sv =====
// Decimal radix sorter.
// The input channel (i_valid, o_stall, i_value, i_last) takes one unsigned value per transfer.
// The values are stored until a transfer with i_last high closes the set. That value is stored
// too, and the sort then starts. Values after the 64th of a set are dropped, and every
// result of that set has o_overflow high.
// Loading accepts one value per cycle. During the sort and the emission o_stall stays high.
// The sort is a least-significant-digit radix sort in base ten. It runs one pass for each
// decimal digit of the set's maximum, so a set whose maximum is zero needs no pass.
// Each pass runs a count scan, a ten-step prefix sum and a scatter scan, and then divides the
// set maximum by ten. The scans stream one element a cycle through the memory read port and
// the shared divide-by-ten unit. During emission the next result is read only once the
// previous one has reached the output register.
// The output channel (o_valid, i_stall, o_sorted_value, o_last_res, o_overflow) carries the
// results in ascending order, with o_last_res on the final one. A stalled result holds in the
// output register, and emission waits for it. After the final transfer is issued the block
// accepts the next set while that result may still wait.
// Reset is synchronous and active low. It clears the control state, and no clearing pass runs.
module decimal_radix_sorter_unit
    import drs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [IO_BITS-1:0] i_value,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IO_BITS-1:0] o_sorted_value,
    output logic               o_last_res,
    output logic               o_overflow
);

    t_state r_state, n_state;

    // Set bookkeeping.
    t_cnt   r_count;
    t_value r_maxq;
    logic   r_dropped;
    logic   r_bank;

    // Two element stores used as ping-pong banks. r_bank holds the current order.
    t_elem  mem0 [MAX_ITEMS];
    t_elem  mem1 [MAX_ITEMS];
    t_elem  r_rd0, r_rd1;
    t_elem  rd_data;

    // Scan pipeline: address issue, then read data, then divider result.
    t_cnt   r_left;
    logic   r_v1, r_v2;
    t_value r_val2;

    // Digit buckets and prefix-sum walk.
    t_cnt   r_bkt [RADIX];
    t_cnt   r_acc;
    t_digit r_j;

    // Emission.
    t_cnt   r_k;
    logic   r_pend;
    logic   r_pend_last;
    logic   r_out_valid;
    logic   [IO_BITS-1:0] r_out_value;
    logic   r_out_last;
    logic   r_out_ovf;

    // Controls decoded from the sequencer state.
    logic   busy, scan, issue, scan_done, prefix_done;
    logic   emit_issue, emit_done;

    logic   in_xfer, out_xfer, load_wr, scat_wr;
    logic   rd_en;
    t_idx   rd_addr;
    t_cnt   left_m1, k_inc;
    t_value in_val;
    t_value div_x, div_quot;
    t_digit div_digit;
    t_digit bkt_sel;
    t_cnt   bkt_rd, bkt_dec;
    t_idx   wr_addr;
    t_elem  wr_data;
    logic   we0, we1;

    assign in_val   = to_val(i_value);
    assign left_m1  = r_left - CNT_W'(1);
    assign k_inc    = r_k + CNT_W'(1);
    assign in_xfer  = i_valid && !busy;
    assign out_xfer = r_out_valid && !i_stall;
    assign rd_data  = r_bank ? r_rd1 : r_rd0;

    always_comb begin
        busy        = (r_state != ST_LOAD);
        scan        = (r_state == ST_COUNT) || (r_state == ST_SCATTER);
        issue       = scan && (r_left != '0);
        scan_done   = scan && (r_left == '0) && !r_v1 && !r_v2;
        prefix_done = (r_state == ST_PREFIX) && (r_j == DIGIT_W'(RADIX - 1));
        emit_issue  = (r_state == ST_EMIT) && !r_pend && (r_k < r_count) &&
                      (!r_out_valid || out_xfer);
        emit_done   = (r_state == ST_EMIT) && !r_pend && (r_k == r_count);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_xfer && i_last) begin
                    n_state = ST_PASS;
                end
            end
            ST_PASS: begin
                n_state = (r_maxq == '0) ? ST_EMIT : ST_COUNT;
            end
            ST_COUNT: begin
                if (scan_done) begin
                    n_state = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                if (prefix_done) begin
                    n_state = ST_SCATTER;
                end
            end
            ST_SCATTER: begin
                if (scan_done) begin
                    n_state = ST_MAXDIV;
                end
            end
            ST_MAXDIV: begin
                n_state = ST_MAXSET;
            end
            ST_MAXSET: begin
                n_state = ST_PASS;
            end
            ST_EMIT: begin
                if (emit_done) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // The shared unit divides streamed quotients during the scans and the set maximum
    // at the end of each pass.
    assign div_x = (r_state == ST_MAXDIV) ? r_maxq : rd_data.quot;

    drs_div10 u_div10 (
        .i_clk   (i_clk),
        .i_x     (div_x),
        .o_quot  (div_quot),
        .o_digit (div_digit)
    );

    // Loading and scattering write different banks, so one write port per bank suffices.
    assign load_wr = in_xfer && (r_count < CNT_W'(MAX_ITEMS));
    assign scat_wr = (r_state == ST_SCATTER) && r_v2;
    assign bkt_sel = (r_state == ST_PREFIX) ? r_j : div_digit;
    assign bkt_rd  = r_bkt[bkt_sel];
    assign bkt_dec = bkt_rd - CNT_W'(1);

    always_comb begin
        if (scat_wr) begin
            wr_addr       = bkt_dec[IDX_W-1:0];
            wr_data.value = r_val2;
            wr_data.quot  = div_quot;
        end else begin
            wr_addr       = r_count[IDX_W-1:0];
            wr_data.value = in_val;
            wr_data.quot  = in_val;
        end
        we0 = (load_wr && !r_bank) || (scat_wr && r_bank);
        we1 = (load_wr && r_bank) || (scat_wr && !r_bank);
    end

    assign rd_en   = issue || emit_issue;
    assign rd_addr = (r_state == ST_EMIT) ? r_k[IDX_W-1:0] : left_m1[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd0 <= mem0[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd1 <= mem1[rd_addr];
        end
    end

    // Set bookkeeping. The count, the maximum and the drop flag return to zero once the
    // set has been emitted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_maxq    <= '0;
            r_dropped <= 1'b0;
            r_bank    <= 1'b0;
        end else begin
            if (in_xfer) begin
                if (load_wr) begin
                    r_count <= r_count + CNT_W'(1);
                    if (in_val > r_maxq) begin
                        r_maxq <= in_val;
                    end
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if ((r_state == ST_SCATTER) && scan_done) begin
                r_bank <= !r_bank;
            end
            if (r_state == ST_MAXSET) begin
                r_maxq <= div_quot;
            end
            if (emit_done) begin
                r_count   <= '0;
                r_maxq    <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    // Scan pipeline control. Both scans walk the elements from the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (issue) begin
                r_left <= left_m1;
            end
            if ((r_state == ST_PASS) || prefix_done) begin
                r_left <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_val2 <= rd_data.value;
        end
    end

    // Buckets are cleared at the start of each pass. The count scan increments them, the prefix
    // walk turns them into end positions, and the scatter scan decrements them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < RADIX; b++) begin
                r_bkt[b] <= '0;
            end
            r_acc <= '0;
            r_j   <= '0;
        end else begin
            case (r_state)
                ST_PASS: begin
                    for (int b = 0; b < RADIX; b++) begin
                        r_bkt[b] <= '0;
                    end
                    r_acc <= '0;
                    r_j   <= '0;
                end
                ST_COUNT: begin
                    if (r_v2) begin
                        r_bkt[bkt_sel] <= bkt_rd + CNT_W'(1);
                    end
                end
                ST_PREFIX: begin
                    r_bkt[bkt_sel] <= bkt_rd + r_acc;
                    r_acc          <= bkt_rd + r_acc;
                    r_j            <= r_j + DIGIT_W'(1);
                end
                ST_SCATTER: begin
                    if (r_v2) begin
                        r_bkt[bkt_sel] <= bkt_dec;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Emission: a read is issued only when the output register will be free as the data
    // arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= emit_issue;
            if (r_state == ST_PASS) begin
                r_k <= '0;
            end else if (emit_issue) begin
                r_k <= k_inc;
            end
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_issue) begin
            r_pend_last <= (k_inc == r_count);
        end
        if (r_pend) begin
            r_out_value <= from_val(rd_data.value);
            r_out_last  <= r_pend_last;
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_stall        = busy;
    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_res     = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== rtl/drs_div10.sv =====
module drs_div10
    import drs_pkg::*;
(
    input  logic   i_clk,
    input  t_value i_x,
    output t_value o_quot,
    output t_digit o_digit
);

    // Results appear in the cycle after the operand.
    logic [2*VALUE_BITS-1:0] r_prod;
    t_value                  r_x;

    logic [2*VALUE_BITS-1:0] prod_sh;
    t_value                  q_est;
    logic [VALUE_BITS+3:0]   q_times;
    logic [VALUE_BITS+3:0]   rem;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*VALUE_BITS)'(i_x) * (2*VALUE_BITS)'(DIV10_RECIP);
        r_x    <= i_x;
    end

    // The estimate is the true quotient or one below it.
    always_comb begin
        prod_sh = r_prod >> DIV10_SHIFT;
        q_est   = prod_sh[VALUE_BITS-1:0];
        q_times = (VALUE_BITS+4)'(q_est) * (VALUE_BITS+4)'(RADIX);
        rem     = (VALUE_BITS+4)'(r_x) - q_times;
        if (rem >= (VALUE_BITS+4)'(RADIX)) begin
            o_quot  = q_est + VALUE_BITS'(1);
            o_digit = DIGIT_W'(rem - (VALUE_BITS+4)'(RADIX));
        end else begin
            o_quot  = q_est;
            o_digit = DIGIT_W'(rem);
        end
    end

endmodule

// ===== rtl/drs_checker.sv =====
module drs_checker
    import drs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_last,
    input logic               o_valid,
    input logic               i_stall,
    input logic [IO_BITS-1:0] o_sorted_value,
    input logic               o_last_res
);

    // A set is closed by its last transfer, and the sort then holds off the input.
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last) |=> o_stall)
        else $error("input not stalled after the last value of a set");

    // Results are produced only during the sort and emission.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_stall)
        else $error("result appeared while the block was loading");

    // The final result of a set is not followed at once by another result.
    a_gap_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_res) |=> !o_valid)
        else $error("result followed the final result of a set immediately");

    // A stalled result holds.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sorted_value)))
        else $error("stalled result changed");

endmodule

bind decimal_radix_sorter_unit drs_checker u_drs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_value (o_sorted_value),
    .o_last_res     (o_last_res)
);
